FILE: rtl/lkvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Entry count, index widths, request/response words and control structs.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	localparam logic [CAP_W-1:0]        CAP_RESET  = CAP_W'(16);
	localparam logic signed [VAL_W-1:0] MISS_VALUE = -VAL_W'(1);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic signed [KEY_W-1:0] req_key;
		logic signed [VAL_W-1:0] req_value;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
	} rsp_t;

	// one stored entry
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	// recency update request
	typedef struct packed {
		logic             touch;
		logic             insert;
		logic             evict;
		logic [IDX_W-1:0] slot;
	} rcy_op_t;

	// recency status
	typedef struct packed {
		logic [ENTRIES-1:0] valid;
		logic [IDX_W-1:0]   free_idx;
		logic [CNT_W-1:0]   occ;
	} rcy_stat_t;

	// zero acts as one, anything above the entry count saturates
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [CNT_W-1:0] r;
		if (cap == '0) begin
			r = CNT_W'(1);
		end else if (int'(cap) > ENTRIES) begin
			r = CNT_W'(ENTRIES);
		end else begin
			r = CNT_W'(cap);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lkvc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_store: key/value entry memory
// One write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lkvc_store (
	input  wire                          clk,
	input  wire                          rd_en,
	input  wire  [lkvc_pkg::IDX_W-1:0]   rd_addr,
	output lkvc_pkg::entry_t             rd_data,
	input  wire                          wr_en,
	input  wire  [lkvc_pkg::IDX_W-1:0]   wr_addr,
	input  lkvc_pkg::entry_t             wr_data
);

	lkvc_pkg::entry_t mem [lkvc_pkg::ENTRIES];
	lkvc_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/lkvc_recency.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_recency: valid bits, recency ranks and occupancy
// Rank 0 is most recent; valid ranks always form 0..occ-1.
// ----------------------------------------------------------------------------
module lkvc_recency (
	input  wire                clk,
	input  wire                arst_n,
	input  lkvc_pkg::rcy_op_t  op,
	output lkvc_pkg::rcy_stat_t stat
);

	logic [lkvc_pkg::ENTRIES-1:0] valid_q;
	logic [lkvc_pkg::IDX_W-1:0]   rank_q [lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::CNT_W-1:0]   occ_q;

	logic [lkvc_pkg::CNT_W-1:0]   occ_m1;
	logic [lkvc_pkg::IDX_W-1:0]   victim;
	logic [lkvc_pkg::ENTRIES-1:0] post_valid;
	logic [lkvc_pkg::IDX_W-1:0]   free_idx;
	logic [lkvc_pkg::IDX_W-1:0]   touch_rank;

	// least recent valid entry carries rank occ-1
	always_comb begin
		occ_m1 = occ_q - lkvc_pkg::CNT_W'(1);
		victim = '0;
		for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
			if (valid_q[j] && rank_q[j] == occ_m1[lkvc_pkg::IDX_W-1:0]) begin
				victim = lkvc_pkg::IDX_W'(j);
			end
		end
	end

	// lowest free slot once the victim is dropped
	always_comb begin
		post_valid = valid_q;
		if (op.evict) begin
			post_valid[victim] = 1'b0;
		end
		free_idx = '0;
		for (int j = lkvc_pkg::ENTRIES - 1; j >= 0; j--) begin
			if (!post_valid[j]) begin
				free_idx = lkvc_pkg::IDX_W'(j);
			end
		end
	end

	assign touch_rank = rank_q[op.slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (op.touch) begin
			for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
				if (valid_q[j] && lkvc_pkg::IDX_W'(j) != op.slot && rank_q[j] < touch_rank) begin
					rank_q[j] <= rank_q[j] + lkvc_pkg::IDX_W'(1);
				end
			end
			rank_q[op.slot] <= '0;
		end else if (op.insert) begin
			for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
				if (post_valid[j]) begin
					rank_q[j] <= rank_q[j] + lkvc_pkg::IDX_W'(1);
				end
			end
			// rank of a dropped entry is never looked at while it is invalid
			if (op.evict) begin
				occ_q <= occ_q;
			end else begin
				occ_q <= occ_q + lkvc_pkg::CNT_W'(1);
			end
			valid_q           <= post_valid | (lkvc_pkg::ENTRIES'(1) << free_idx);
			rank_q[free_idx]  <= '0;
		end
	end

	assign stat.valid    = valid_q;
	assign stat.free_idx = free_idx;
	assign stat.occ      = occ_q;

endmodule
`default_nettype wire

FILE: rtl/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Requests are taken one at a time: a new request word is accepted only in idle,
//   after the serial key scan through the single read port of the entry memory
//   and the update of the last one; a get waits in update until the output is free.
// Reset: arst_n clears all valid bits, ranks, occupancy and the handshake
//   state at once; capacity returns to 16. Entry memory is not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
	input  wire                          clk,
	input  wire                          arst_n,
	// request channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  lkvc_pkg::req_t               in_word,
	// response channel (gets only)
	output logic                         out_valid,
	input  wire                          out_stall,
	output lkvc_pkg::rsp_t               out_word,
	// capacity register
	input  wire                          cfg_we,
	input  wire  [lkvc_pkg::CAP_W-1:0]   cfg_data
);

	// one-hot sequencer
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [lkvc_pkg::CAP_W-1:0] cap_q;
	lkvc_pkg::req_t             req_q;

	// scan bookkeeping
	logic [lkvc_pkg::CNT_W-1:0] issue_q;
	logic                       rd_vld_s1;
	logic [lkvc_pkg::IDX_W-1:0] rd_idx_s1;
	logic                       found_q;
	logic [lkvc_pkg::IDX_W-1:0] slot_q;
	logic signed [lkvc_pkg::VAL_W-1:0] val_q;

	// output register
	logic                       out_valid_q;
	lkvc_pkg::rsp_t             out_word_q;

	logic                       in_acc;
	logic                       out_ready;
	logic                       rd_en;
	logic [lkvc_pkg::IDX_W-1:0] rd_addr;
	lkvc_pkg::entry_t           rd_data;
	logic                       wr_en;
	logic [lkvc_pkg::IDX_W-1:0] wr_addr;
	lkvc_pkg::entry_t           wr_data;
	logic                       match;
	logic                       scan_last;
	logic                       is_set;
	logic                       upd_done;
	logic                       out_load;

	lkvc_pkg::rcy_op_t          rop;
	lkvc_pkg::rcy_stat_t        rstat;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_ready = !out_valid_q || !out_stall;
	assign is_set    = (req_q.cmd == lkvc_pkg::CMD_SET);

	// entry 0 is read on the accept edge, the rest during the scan
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == ST_IDLE) begin
			rd_en = in_acc;
		end else if (state_q == ST_SCAN && issue_q != lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES)) begin
			rd_en   = 1'b1;
			rd_addr = issue_q[lkvc_pkg::IDX_W-1:0];
		end
	end

	// compare stage: valid entry holding the requested key
	assign match = rd_vld_s1 && rstat.valid[rd_idx_s1] && !found_q &&
		(rd_data.key == req_q.req_key);
	assign scan_last = rd_vld_s1 &&
		(rd_idx_s1 == lkvc_pkg::IDX_W'(lkvc_pkg::ENTRIES - 1));

	// update cycle: a get waits there until the output register is free
	assign upd_done = (state_q == ST_UPDATE) && (is_set || out_ready);
	assign out_load = (state_q == ST_UPDATE) && !is_set && out_ready;

	always_comb begin
		rop.touch  = upd_done && found_q;
		rop.insert = (state_q == ST_UPDATE) && is_set && !found_q;
		rop.evict  = rop.insert && (rstat.occ >= lkvc_pkg::eff_cap(cap_q));
		rop.slot   = slot_q;
	end

	// set hit rewrites in place, set miss fills the freed or first empty slot
	assign wr_en         = (state_q == ST_UPDATE) && is_set;
	assign wr_addr       = found_q ? slot_q : rstat.free_idx;
	assign wr_data.key   = req_q.req_key;
	assign wr_data.value = req_q.req_value;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (upd_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= lkvc_pkg::CAP_RESET;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (in_acc) begin
				issue_q <= lkvc_pkg::CNT_W'(1);
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					issue_q <= issue_q + lkvc_pkg::CNT_W'(1);
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (in_acc) begin
			req_q <= in_word;
		end
		if (match) begin
			slot_q <= rd_idx_s1;
			val_q  <= rd_data.value;
		end
		if (out_load) begin
			out_word_q.hit        <= found_q;
			out_word_q.read_value <= found_q ? val_q : lkvc_pkg::MISS_VALUE;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	lkvc_store u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lkvc_recency u_recency (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (rop),
		.stat   (rstat)
	);

endmodule
`default_nettype wire

FILE: rtl/lkvc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Bound to the top level; watches the request and response channels.
// ----------------------------------------------------------------------------
module lkvc_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            in_valid,
	input wire            in_stall,
	input wire            out_valid,
	input wire            out_stall,
	input lkvc_pkg::rsp_t out_word
);

	// a stalled response word holds
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("response word changed under stall");

	// one request at a time: accepting closes the input
	ast_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	// a miss always reads as minus one
	ast_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.hit |-> out_word.read_value == lkvc_pkg::MISS_VALUE)
		else $error("miss word without minus one");

	// a new response only comes out of a busy cycle
	ast_rsp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("response without a request in flight");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU key-value cache
// Gets and sets are driven with random gaps on both channels. Each accepted
// request word updates a bench-side copy of the cache, and each accepted
// response word is checked against the oldest predicted get result. The
// capacity register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
	import lkvc_pkg::*;

	// cycles the receiver holds off while the sender keeps pushing gets
	localparam int HOLD_CYCLES    = 160;
	// a set makes no response; allow a full request slot plus margin before
	// touching the register or ending the run
	localparam int SETTLE_CYCLES  = 24;
	// cycles with no accepted word on either channel before giving up
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS    = 10;

	// ------------------------------------------------------------------------
	// Cache predictor and store of expected get results
	// ------------------------------------------------------------------------
	class lru_scoreboard;
		logic [KEY_W-1:0] slot_key   [ENTRIES];
		logic [VAL_W-1:0] slot_value [ENTRIES];
		bit               slot_used  [ENTRIES];
		int unsigned      slot_age   [ENTRIES]; // 0 is most recent
		int unsigned      occupancy;
		logic [CAP_W-1:0] capacity;
		rsp_t             pending_reads [$];
		int               mismatches;

		function new();
			capacity   = CAP_RESET;
			occupancy  = 0;
			mismatches = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_age[i]  = 0;
			end
		endfunction

		// zero behaves as one, anything past the array saturates
		function int unsigned usable_slots();
			if (capacity == '0)
				return 1;
			if (int'(capacity) > ENTRIES)
				return ENTRIES;
			return capacity;
		endfunction

		function int find_slot(logic [KEY_W-1:0] key);
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && slot_key[i] == key)
					return i;
			return -1;
		endfunction

		function void make_newest(int slot);
			for (int j = 0; j < ENTRIES; j++)
				if (slot_used[j] && j != slot && slot_age[j] < slot_age[slot])
					slot_age[j]++;
			slot_age[slot] = 0;
		endfunction

		function void note_request(req_t req);
			int   slot;
			int   oldest;
			int   free_slot;
			rsp_t rsp;
			slot = find_slot(req.req_key);
			if (req.cmd == CMD_SET) begin
				if (slot >= 0) begin
					slot_value[slot] = req.req_value;
					make_newest(slot);
				end else begin
					// full (or over a lowered capacity): drop exactly one, the oldest
					if (occupancy >= usable_slots()) begin
						oldest = -1;
						for (int j = 0; j < ENTRIES; j++)
							if (slot_used[j] && (oldest < 0 || slot_age[j] > slot_age[oldest]))
								oldest = j;
						if (oldest >= 0) begin
							slot_used[oldest] = 1'b0;
							slot_age[oldest]  = 0;
							occupancy--;
						end
					end
					free_slot = -1;
					for (int j = 0; j < ENTRIES; j++)
						if (!slot_used[j] && free_slot < 0)
							free_slot = j;
					if (free_slot >= 0) begin
						for (int j = 0; j < ENTRIES; j++)
							if (slot_used[j])
								slot_age[j]++;
						slot_key[free_slot]   = req.req_key;
						slot_value[free_slot] = req.req_value;
						slot_used[free_slot]  = 1'b1;
						slot_age[free_slot]   = 0;
						occupancy++;
					end
				end
			end else begin
				if (slot >= 0) begin
					make_newest(slot);
					rsp.hit        = 1'b1;
					rsp.read_value = slot_value[slot];
				end else begin
					rsp.hit        = 1'b0;
					rsp.read_value = MISS_VALUE;
				end
				pending_reads.push_back(rsp);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected read word: hit=%0b value=%0d", got.hit, got.read_value);
				return;
			end
			want = pending_reads.pop_front();
			if (got.hit !== want.hit || got.read_value !== want.read_value) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("read mismatch: expected hit=%0b value=%0d, got hit=%0b value=%0d",
						want.hit, want.read_value, got.hit, got.read_value);
			end
		endfunction

		function int outstanding();
			return pending_reads.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and DUT
	// ------------------------------------------------------------------------
	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	req_t             in_word;
	logic             out_valid;
	logic             out_stall;
	rsp_t             out_word;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_data;

	lru_scoreboard    sb;
	logic [KEY_W-1:0] key_pool [$];
	// quiet flags switch off the random gaps; rx_hold asks for one long stall
	bit               tx_quiet = 1'b0;
	bit               rx_quiet = 1'b0;
	bit               rx_hold  = 1'b0;
	int               idle_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lru_key_value_cache DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Monitor: both channels sampled at the rising edge. The response is
	// checked before the request is noted so a stray word is never hidden by
	// a get accepted in the same cycle. Also runs the watchdog.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_response(out_word);
			if (in_valid && !in_stall)
				sb.note_request(in_word);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: per word, stall for a random length (or none when quiet, or
	// HOLD_CYCLES when a hold is asked), then drop stall and wait for the word
	// to be taken.
	// ------------------------------------------------------------------------
	initial begin
		int stall_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = rx_quiet ? 0 : $urandom_range(0, 14);
			if (rx_hold) begin
				stall_len = HOLD_CYCLES;
				rx_hold   = 1'b0;
			end
			if (stall_len > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (stall_len - 1) @(negedge clk);
			end
			@(negedge clk) out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks
	// ------------------------------------------------------------------------
	function automatic req_t make_req(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		req_t r;
		r.cmd       = cmd;
		r.req_key   = key;
		r.req_value = value;
		return r;
	endfunction

	// mostly uniform, with the signed extremes and all-ones mixed in
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: begin
				return 32'h7FFF_FFFF;
			end
			1: begin
				return 32'h8000_0000;
			end
			2: begin
				return 32'hFFFF_FFFF;
			end
			3: begin
				return 32'h0000_0000;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// valid stays up across back-to-back words; payload holds while stalled
	task automatic send_word(input req_t w);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// sender pause: everything answered, then room for a trailing set
	task automatic wait_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		sb.capacity = cap;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic fill_pool(input int size);
		key_pool.delete();
		for (int i = 0; i < size; i++)
			key_pool.push_back(pick_word());
	endtask

	// most keys come from a small pool so hits and evictions are common
	task automatic send_random(input int count, input int set_pct);
		logic [KEY_W-1:0] key;
		logic             cmd;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 85)
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else
				key = $urandom;
			cmd = ($urandom_range(0, 99) < set_pct) ? CMD_SET : CMD_GET;
			send_word(make_req(cmd, key, pick_word()));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [CAP_W-1:0] phase_caps [10];
		sb        = new();
		in_valid  = 1'b0;
		in_word   = '0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		phase_caps = '{5'd16, 5'd1, 5'd0, 5'd3, 5'd31, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset capacity of 16.
		// get on an empty cache
		send_word(make_req(CMD_GET, 32'h0000_0000, 32'h0000_0000));
		// key and value extremes
		send_word(make_req(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF));
		send_word(make_req(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000));
		// stored -1 must come back with hit set, unlike a miss
		send_word(make_req(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_word(make_req(CMD_SET, 32'h0000_0000, 32'h0000_0000));
		send_word(make_req(CMD_GET, 32'h8000_0000, 32'h0000_0000));
		send_word(make_req(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000));
		send_word(make_req(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000));
		// overwrite of a present key
		send_word(make_req(CMD_SET, 32'h7FFF_FFFF, 32'h0000_0005));
		send_word(make_req(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000));
		// miss; the value field of a get is ignored
		send_word(make_req(CMD_GET, 32'h1234_5678, 32'hFFFF_FFFF));

		// capacity dropped under occupancy: each new key evicts one, count holds
		write_capacity(5'd2);
		send_word(make_req(CMD_SET, 32'h0000_0011, 32'h0000_0001));
		send_word(make_req(CMD_GET, 32'h0000_0000, 32'h0000_0000));
		send_word(make_req(CMD_GET, 32'h0000_0011, 32'h0000_0000));
		send_word(make_req(CMD_SET, 32'h0000_0022, 32'h0000_0002));
		send_word(make_req(CMD_GET, 32'h8000_0000, 32'h0000_0000));

		// zero capacity acts as one
		write_capacity(5'd0);
		send_word(make_req(CMD_SET, 32'h0000_0033, 32'h0000_0003));
		send_word(make_req(CMD_GET, 32'h0000_0033, 32'h0000_0000));

		// Random phases, one capacity each; every third phase without gaps.
		for (int p = 0; p < 10; p++) begin
			write_capacity(phase_caps[p]);
			fill_pool($urandom_range(2, 20));
			tx_quiet = (p % 3 == 2);
			rx_quiet = (p % 3 == 2);
			send_random(20, 45);
			if (p == 4) begin
				// long receiver hold while gets keep coming: the block backs up
				// into its request side
				rx_hold  = 1'b1;
				tx_quiet = 1'b1;
				send_random(12, 0);
				tx_quiet = 1'b0;
			end
			send_random(20, 45);
		end

		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		wait_idle();
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
